@@ hdl/rkbt_pkg.sv @@
// ----------------------------------------------------------------------------
// rkbt_pkg
// Shared types and constants of the revoked key bucket table.
// ----------------------------------------------------------------------------
package rkbt_pkg;

   localparam int DEF_WAYS  = 8;
   localparam int BUCKETS   = 256;
   localparam int BUCKET_W  = 8;
   localparam int KEY_HIGH_W = 16;
   localparam int KEY_LOW_W  = 64;
   localparam int MID_W     = KEY_LOW_W - BUCKET_W;
   localparam int KEY_W     = KEY_HIGH_W + MID_W;
   localparam int LIMIT_W   = 4;
   localparam int SLOT_W    = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]            kind;
      logic [KEY_HIGH_W-1:0] key_high;
      logic [KEY_LOW_W-1:0]  key_low;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } count_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } key_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage

@@ hdl/rkbt_count_store.sv @@
// ----------------------------------------------------------------------------
// rkbt_count_store
// Per-bucket fill counts: one RAM plus a valid bit per bucket so that reset
// and flush empty every bucket at once.
// ----------------------------------------------------------------------------
module rkbt_count_store
   import rkbt_pkg::*;
#(
   parameter int WAYS = DEF_WAYS,
   localparam int CW  = $clog2(WAYS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  count_ctl_type       ctl,
   input  logic [BUCKET_W-1:0] rd_addr,
   input  logic [BUCKET_W-1:0] wr_addr,
   input  logic [CW-1:0]       wr_data,
   output logic [CW-1:0]       rd_data
);

   logic [CW-1:0]      count_mem [BUCKETS];
   logic [CW-1:0]      rd_data_ff;
   logic               rd_valid_ff;
   logic [BUCKETS-1:0] valid_ff;
   logic [BUCKETS-1:0] valid_in;

   // clear beats a write; the controller never issues both together
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= count_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // an emptied bucket reads as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ hdl/rkbt_key_store.sv @@
// ----------------------------------------------------------------------------
// rkbt_key_store
// Single-port RAM of stored key bytes, WAYS slots per bucket.
// ----------------------------------------------------------------------------
module rkbt_key_store
   import rkbt_pkg::*;
#(
   parameter int WAYS = DEF_WAYS,
   localparam int AW  = $clog2(BUCKETS * WAYS)
) (
   input  logic             clock,
   input  key_ctl_type      ctl,
   input  logic [AW-1:0]    addr,
   input  logic [KEY_W-1:0] wr_data,
   output logic [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0] key_mem [BUCKETS * WAYS];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         key_mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= key_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rkbt_ctrl.sv @@
// ----------------------------------------------------------------------------
// rkbt_ctrl
// Request sequencer: reads the bucket count, scans the bucket slot by slot,
// then appends or reports, and drives the one-cycle result strobe.
// ----------------------------------------------------------------------------
module rkbt_ctrl
   import rkbt_pkg::*;
#(
   parameter int WAYS = DEF_WAYS,
   localparam int CW  = $clog2(WAYS + 1),
   localparam int AW  = $clog2(BUCKETS * WAYS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_item,
   output logic                rsp_strobe,
   output rsp_type             rsp_item,
   input  logic [CW-1:0]       eff_limit,
   output count_ctl_type       count_ctl,
   output logic [BUCKET_W-1:0] count_rd_addr,
   output logic [BUCKET_W-1:0] count_wr_addr,
   output logic [CW-1:0]       count_wr_data,
   input  logic [CW-1:0]       count_rd_data,
   output key_ctl_type         key_ctl,
   output logic [AW-1:0]       key_addr,
   output logic [KEY_W-1:0]    key_wr_data,
   input  logic [KEY_W-1:0]    key_rd_data
);

   localparam logic [AW-1:0] WAYS_A = AW'(WAYS);

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] idx_ff, idx_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_strobe_ff, rsp_strobe_in;

   logic                accept;
   logic [BUCKET_W-1:0] bucket;
   logic [AW-1:0]       base;
   logic [KEY_W-1:0]    key_word;
   logic                match;
   logic                last_slot;
   logic                room;
   logic [CW-1:0]       idx_next;

   assign accept    = start && (state_ff == ST_IDLE);
   assign bucket    = req_ff.key_low[BUCKET_W-1:0];
   assign base      = AW'(AW'(bucket) * WAYS_A);
   assign key_word  = {req_ff.key_high, req_ff.key_low[KEY_LOW_W-1:BUCKET_W]};
   assign match     = (key_rd_data == key_word);
   assign idx_next  = CW'(idx_ff + 1'b1);
   assign last_slot = (idx_next == fill_ff);
   assign room      = (fill_ff < eff_limit);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.kind == KIND_LOOKUP || req_item.kind == KIND_ADD)) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            state_in = (count_rd_data == '0) ? ST_DECIDE : ST_SCAN;
         end
         ST_SCAN: begin
            priority if (match) begin
               state_in = ST_IDLE;
            end else if (last_slot) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_in        = req_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      rsp_in        = '0;
      rsp_strobe_in = 1'b0;
      count_ctl     = '0;
      count_rd_addr = req_item.key_low[BUCKET_W-1:0];
      count_wr_addr = bucket;
      count_wr_data = CW'(fill_ff + 1'b1);
      key_ctl       = '0;
      key_addr      = AW'(base + AW'(idx_ff));
      key_wr_data   = key_word;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_item;
               unique case (req_item.kind)
                  KIND_LOOKUP, KIND_ADD: begin
                     count_ctl.rd_en = 1'b1;
                  end
                  KIND_FLUSH: begin
                     count_ctl.clear = 1'b1;
                     rsp_strobe_in   = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_COUNT: begin
            fill_in       = count_rd_data;
            idx_in        = '0;
            key_ctl.rd_en = (count_rd_data != '0);
            key_addr      = base;
         end
         ST_SCAN: begin
            priority if (match) begin
               rsp_in.hit    = 1'b1;
               rsp_in.slot   = SLOT_W'(idx_ff);
               rsp_strobe_in = 1'b1;
            end else if (!last_slot) begin
               idx_in        = idx_next;
               key_ctl.rd_en = 1'b1;
               key_addr      = AW'(base + AW'(idx_next));
            end
         end
         ST_DECIDE: begin
            rsp_strobe_in = 1'b1;
            if (req_ff.kind == KIND_ADD) begin
               if (room) begin
                  key_ctl.wr_en   = 1'b1;
                  key_addr        = AW'(base + AW'(fill_ff));
                  count_ctl.wr_en = 1'b1;
                  rsp_in.slot     = SLOT_W'(fill_ff);
               end else begin
                  rsp_in.status = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      fill_ff <= fill_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef ASSERT_OFF
   // every accepted beat is either still in work or answered next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("accepted request neither in progress nor answered");

   // a full-bucket failure never carries a hit
   a_fail_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_item.hit && rsp_item.status))
      else $error("result reports both hit and failure");

   // appends only on a miss of an add with room left
   a_append_guard: assert property (@(posedge clock) disable iff (reset)
      key_ctl.wr_en |-> (state_ff == ST_DECIDE && req_ff.kind == KIND_ADD && room))
      else $error("key written outside a permitted append");

   // the scan index never passes the bucket fill
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff < fill_ff))
      else $error("scan index beyond bucket fill");

   // count and key writes travel together
   a_write_pair: assert property (@(posedge clock) disable iff (reset)
      count_ctl.wr_en == key_ctl.wr_en)
      else $error("count and key writes out of step");
`endif

endmodule

@@ hdl/revoked_key_bucket_table_unit.sv @@
// ----------------------------------------------------------------------------
// revoked_key_bucket_table_unit
// Bucketed table of revoked 80-bit certificate hashes with lookup, add and
// flush requests.
// ----------------------------------------------------------------------------
//
//   channel   ports                          handshake
//   --------  -----------------------------  ---------------------------------
//   request   start, busy, req_item          beat taken when start && !busy
//   result    rsp_strobe, rsp_item           one-cycle strobe, never stalled
//   config    csr_wr_en, csr_wr_data         bucket_limit written on enable
//
// Flush and unused kinds answer in the cycle after the beat is taken.
// Lookup and add make one count RAM read, then one key RAM read per slot
// through the single key RAM port, up to the bucket fill (at most WAYS);
// a hit answers from the scan, a miss goes on to the decision.
// Reset empties every bucket at once through per-bucket valid bits; flush
// does the same in its accept cycle. No clearing pass is needed.
// busy holds off new beats while a request is in work; the result side
// cannot stall, so a result leaves on its strobe cycle unconditionally.
// ----------------------------------------------------------------------------
module revoked_key_bucket_table_unit
   import rkbt_pkg::*;
#(
   parameter int WAYS = DEF_WAYS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   output logic               rsp_strobe,
   output rsp_type            rsp_item,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   localparam int CW = $clog2(WAYS + 1);
   localparam int AW = $clog2(BUCKETS * WAYS);
   // common width for comparing the limit register with WAYS
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LW-1:0]      limit_wide;
   logic [CW-1:0]      eff_limit;

   count_ctl_type       count_ctl;
   logic [BUCKET_W-1:0] count_rd_addr;
   logic [BUCKET_W-1:0] count_wr_addr;
   logic [CW-1:0]       count_wr_data;
   logic [CW-1:0]       count_rd_data;
   key_ctl_type         key_ctl;
   logic [AW-1:0]       key_addr;
   logic [KEY_W-1:0]    key_wr_data;
   logic [KEY_W-1:0]    key_rd_data;

   // bucket_limit register: take the write data on the enable beat
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // clamp the limit to the slots a bucket really has
   always_comb begin
      limit_wide = LW'(limit_ff);
      if (limit_wide > LW'(WAYS)) begin
         limit_wide = LW'(WAYS);
      end
      eff_limit = CW'(limit_wide);
   end

   // sequencer: count read, slot scan, append or report
   rkbt_ctrl #(
      .WAYS(WAYS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .rsp_strobe   (rsp_strobe),
      .rsp_item     (rsp_item),
      .eff_limit    (eff_limit),
      .count_ctl    (count_ctl),
      .count_rd_addr(count_rd_addr),
      .count_wr_addr(count_wr_addr),
      .count_wr_data(count_wr_data),
      .count_rd_data(count_rd_data),
      .key_ctl      (key_ctl),
      .key_addr     (key_addr),
      .key_wr_data  (key_wr_data),
      .key_rd_data  (key_rd_data)
   );

   // fill count per bucket, cleared at once by reset or flush
   rkbt_count_store #(
      .WAYS(WAYS)
   ) u_count_store (
      .clock  (clock),
      .reset  (reset),
      .ctl    (count_ctl),
      .rd_addr(count_rd_addr),
      .wr_addr(count_wr_addr),
      .wr_data(count_wr_data),
      .rd_data(count_rd_data)
   );

   // stored key bytes; the bucket byte is implied by the address
   rkbt_key_store #(
      .WAYS(WAYS)
   ) u_key_store (
      .clock  (clock),
      .ctl    (key_ctl),
      .addr   (key_addr),
      .wr_data(key_wr_data),
      .rd_data(key_rd_data)
   );

endmodule
